@@ hw/rtl/tmcm_pkg.sv @@
package tmcm_pkg;

    localparam int DISP_W   = 16;
    localparam int CNT_W    = 7;
    localparam int INV_W    = 2;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST   = 7'd3;
    localparam logic [DISP_W-1:0] DISPLAY_WIDTH_RST  = 16'd320;
    localparam logic [DISP_W-1:0] DISPLAY_HEIGHT_RST = 16'd240;

    typedef enum logic [2:0] {
        REG_SAMPLE_COUNT   = 3'd0,
        REG_PANEL_X_MIN    = 3'd1,
        REG_PANEL_X_MAX    = 3'd2,
        REG_PANEL_Y_MIN    = 3'd3,
        REG_PANEL_Y_MAX    = 3'd4,
        REG_DISPLAY_WIDTH  = 3'd5,
        REG_DISPLAY_HEIGHT = 3'd6,
        REG_INVERT_MODE    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic acc_en;
        logic clear;
        logic mean_start;
        logic mean_load;
        logic prod_load;
        logic scale_start;
        logic disp_load;
    } lane_ctrl_t;

    typedef struct packed {
        logic div_done;
    } lane_stat_t;

endpackage

@@ hw/rtl/tmcm_div.sv @@
module tmcm_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    import tmcm_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    // One quotient bit per cycle; the numerator shifts out of the top of
    // the quotient register while the new bits enter at the bottom.
    assign trial    = {rem_reg, quot_reg[NUM_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NUM_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (run_reg) begin
            quot_reg <= {quot_reg[NUM_W-2:0], ge};
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ hw/rtl/tmcm_lane.sv @@
module tmcm_lane #(
    parameter int SAMPLE_BITS = 12,
    parameter int SUM_W       = 18,
    parameter int NW          = 7,
    parameter int NUM_W       = 28,
    parameter int DEN_W       = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tmcm_pkg::lane_ctrl_t        ctrl,
    output tmcm_pkg::lane_stat_t        stat,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  logic [NW-1:0]               n_set,
    input  logic [SAMPLE_BITS-1:0]      pmin,
    input  logic [SAMPLE_BITS-1:0]      pmax,
    input  logic [tmcm_pkg::DISP_W-1:0] size,
    input  logic                        mirror,
    output logic [SAMPLE_BITS-1:0]      mean,
    output logic [tmcm_pkg::DISP_W-1:0] disp
);
    import tmcm_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + DISP_W;

    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] hi_reg;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [DISP_W-1:0]      disp_reg;

    logic [SUM_W-1:0]       trim;
    logic [SAMPLE_BITS-1:0] off;
    logic                   span_ok;
    logic [SAMPLE_BITS-1:0] span;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic                   div_done;
    logic [NUM_W-1:0]       quot;
    logic [NUM_W-1:0]       scaled;
    logic [DISP_W-1:0]      clamped;
    logic [DISP_W-1:0]      disp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            sum_reg <= '0;
            hi_reg  <= '0;
            lo_reg  <= '1;
        end else if (ctrl.acc_en) begin
            sum_reg <= sum_reg + SUM_W'(sample);
            if (sample > hi_reg) begin
                hi_reg <= sample;
            end
            if (sample < lo_reg) begin
                lo_reg <= sample;
            end
        end
    end

    // The sum always contains both extremes, so this never goes negative.
    assign trim    = sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);
    assign off     = (mean_reg > pmin) ? mean_reg - pmin : '0;
    assign span_ok = pmax > pmin;
    assign span    = pmax - pmin;

    assign div_num = ctrl.mean_start ? NUM_W'(trim) : NUM_W'(prod_reg);
    assign div_den = ctrl.mean_start ? DEN_W'(n_set - NW'(2)) : DEN_W'(span);

    tmcm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.mean_start | ctrl.scale_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (quot)
    );

    // An empty or inverted panel span saturates the scaled value to the size.
    assign scaled    = span_ok ? quot : NUM_W'(size);
    assign clamped   = (scaled > NUM_W'(size)) ? size : scaled[DISP_W-1:0];
    assign disp_next = mirror ? size - clamped : clamped;

    always_ff @(posedge aclk) begin
        if (ctrl.mean_load) begin
            mean_reg <= quot[SAMPLE_BITS-1:0];
        end
        if (ctrl.prod_load) begin
            prod_reg <= PROD_W'(off) * PROD_W'(size);
        end
        if (ctrl.disp_load) begin
            disp_reg <= disp_next;
        end
    end

    assign stat.div_done = div_done;
    assign mean          = mean_reg;
    assign disp          = disp_reg;

endmodule

@@ hw/rtl/touch_trimmed_mean_coordinate_map_top.sv @@
// The last sample of a set leaves its result in the output register after two
// passes through each lane's one-bit-per-cycle divider (trimmed mean, then
// scaling) and a wait until the output register is free.
// Throughput: one sample per cycle inside a set; the input stalls while a set is reduced.
// Reset (aresetn, synchronous, active low) restores the register defaults,
// clears the running set and the last touched point, and empties the output.
module touch_trimmed_mean_coordinate_map_top #(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: x_sample, y_sample (from bit 0 up)
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: panel_x, panel_y, display_x, display_y (from bit 0 up)
    output logic [((2*SAMPLE_BITS+2*tmcm_pkg::DISP_W+7)/8)*8-1:0] m_tdata,
    // m_tuser: touched
    output logic                         m_tuser,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmcm_pkg::APB_AW-1:0]  paddr,
    input  logic [tmcm_pkg::APB_DW-1:0]  pwdata,
    output logic [tmcm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import tmcm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int NW     = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W  = (NW > CNT_W) ? NW : CNT_W;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int PROD_W = SAMPLE_BITS + DISP_W;
    localparam int NUM_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DEN_W  = (SAMPLE_BITS > NW) ? SAMPLE_BITS : NW;
    localparam int RES_W  = 2*SAMPLE_BITS + 2*DISP_W;
    localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

    typedef enum logic [6:0] {
        ST_ACC        = 7'b0000001,
        ST_MEAN_GO    = 7'b0000010,
        ST_MEAN_WAIT  = 7'b0000100,
        ST_MUL        = 7'b0001000,
        ST_SCALE_GO   = 7'b0010000,
        ST_SCALE_WAIT = 7'b0100000,
        ST_OUT        = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]       sample_count_reg;
    logic [SAMPLE_BITS-1:0] panel_x_min_reg, panel_x_max_reg;
    logic [SAMPLE_BITS-1:0] panel_y_min_reg, panel_y_max_reg;
    logic [DISP_W-1:0]      display_width_reg, display_height_reg;
    logic [INV_W-1:0]       invert_mode_reg;

    logic [IDX_W-1:0]       idx_reg;
    logic [NW-1:0]          n_set_reg;
    logic [DISP_W-1:0]      last_x_reg, last_y_reg;
    logic                   out_valid_reg;
    logic                   out_touched_reg;
    logic [RES_W-1:0]       out_data_reg;

    lane_ctrl_t             ctrl;
    lane_stat_t             stat_x, stat_y;
    logic [SAMPLE_BITS-1:0] x_sample, y_sample;
    logic [SAMPLE_BITS-1:0] mean_x, mean_y;
    logic [DISP_W-1:0]      disp_x, disp_y;

    logic                   cfg_wr;
    reg_idx_t               cfg_idx;
    logic [CMP_W-1:0]       n_clamp;
    logic [CMP_W-1:0]       idx_plus;
    logic                   in_xfer;
    logic                   set_end;
    logic                   out_free;
    logic                   touched;
    logic [DISP_W-1:0]      res_x, res_y;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg   <= SAMPLE_COUNT_RST;
            panel_x_min_reg    <= '0;
            panel_x_max_reg    <= '1;
            panel_y_min_reg    <= '0;
            panel_y_max_reg    <= '1;
            display_width_reg  <= DISPLAY_WIDTH_RST;
            display_height_reg <= DISPLAY_HEIGHT_RST;
            invert_mode_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SAMPLE_COUNT:   sample_count_reg   <= pwdata[CNT_W-1:0];
                REG_PANEL_X_MIN:    panel_x_min_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_PANEL_X_MAX:    panel_x_max_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_PANEL_Y_MIN:    panel_y_min_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_PANEL_Y_MAX:    panel_y_max_reg    <= pwdata[SAMPLE_BITS-1:0];
                REG_DISPLAY_WIDTH:  display_width_reg  <= pwdata[DISP_W-1:0];
                REG_DISPLAY_HEIGHT: display_height_reg <= pwdata[DISP_W-1:0];
                REG_INVERT_MODE:    invert_mode_reg    <= pwdata[INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SAMPLE_COUNT:   prdata = APB_DW'(sample_count_reg);
            REG_PANEL_X_MIN:    prdata = APB_DW'(panel_x_min_reg);
            REG_PANEL_X_MAX:    prdata = APB_DW'(panel_x_max_reg);
            REG_PANEL_Y_MIN:    prdata = APB_DW'(panel_y_min_reg);
            REG_PANEL_Y_MAX:    prdata = APB_DW'(panel_y_max_reg);
            REG_DISPLAY_WIDTH:  prdata = APB_DW'(display_width_reg);
            REG_DISPLAY_HEIGHT: prdata = APB_DW'(display_height_reg);
            REG_INVERT_MODE:    prdata = APB_DW'(invert_mode_reg);
            default:            prdata = '0;
        endcase
    end

    // Set size saturated to the range three to MAX_SAMPLES.
    always_comb begin
        if (CMP_W'(sample_count_reg) < CMP_W'(3)) begin
            n_clamp = CMP_W'(3);
        end else if (CMP_W'(sample_count_reg) > CMP_W'(MAX_SAMPLES)) begin
            n_clamp = CMP_W'(MAX_SAMPLES);
        end else begin
            n_clamp = CMP_W'(sample_count_reg);
        end
    end

    assign x_sample = s_tdata[SAMPLE_BITS-1:0];
    assign y_sample = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign s_tready = (state_reg == ST_ACC);
    assign in_xfer  = s_tvalid & s_tready;
    assign idx_plus = CMP_W'(idx_reg) + CMP_W'(1);
    assign set_end  = idx_plus >= n_clamp;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_ACC: begin
                ctrl.acc_en = in_xfer;
                if (in_xfer && set_end) begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO: begin
                ctrl.mean_start = 1'b1;
                ctrl.clear      = 1'b1;
                state_next      = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (stat_x.div_done && stat_y.div_done) begin
                    ctrl.mean_load = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL: begin
                ctrl.prod_load = 1'b1;
                state_next     = ST_SCALE_GO;
            end
            ST_SCALE_GO: begin
                ctrl.scale_start = 1'b1;
                state_next       = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT: begin
                if (stat_x.div_done && stat_y.div_done) begin
                    ctrl.disp_load = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            idx_reg   <= '0;
            n_set_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (in_xfer) begin
                if (set_end) begin
                    idx_reg   <= '0;
                    n_set_reg <= NW'(idx_plus);
                end else begin
                    idx_reg <= IDX_W'(idx_plus);
                end
            end
        end
    end

    tmcm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .NW          (NW),
        .NUM_W       (NUM_W),
        .DEN_W       (DEN_W)
    ) u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat_x),
        .sample  (x_sample),
        .n_set   (n_set_reg),
        .pmin    (panel_x_min_reg),
        .pmax    (panel_x_max_reg),
        .size    (display_width_reg),
        .mirror  (invert_mode_reg[0]),
        .mean    (mean_x),
        .disp    (disp_x)
    );

    tmcm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .NW          (NW),
        .NUM_W       (NUM_W),
        .DEN_W       (DEN_W)
    ) u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat_y),
        .sample  (y_sample),
        .n_set   (n_set_reg),
        .pmin    (panel_y_min_reg),
        .pmax    (panel_y_max_reg),
        .size    (display_height_reg),
        .mirror  (invert_mode_reg[1]),
        .mean    (mean_y),
        .disp    (disp_y)
    );

    // Both lanes map every set; the mapped point is kept only when touched.
    assign touched = (mean_x != '0) && (mean_y != '0);
    assign res_x   = touched ? disp_x : last_x_reg;
    assign res_y   = touched ? disp_y : last_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
        end else if (state_reg == ST_OUT && out_free) begin
            out_valid_reg <= 1'b1;
            last_x_reg    <= res_x;
            last_y_reg    <= res_y;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            out_touched_reg <= touched;
            out_data_reg    <= {res_y, res_x, mean_y, mean_x};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_touched_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule
